### design/swps_pkg.sv
// Package for the side-wall steering block: widths, fixed tuning constants
// and configuration register indexes. No dependencies.
`default_nettype none

package swps_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int SLOPE_BITS  = SAMPLE_BITS + 1;
    localparam int ERR_BITS    = SAMPLE_BITS + 2;
    localparam int DIFF_BITS   = ERR_BITS + 1;
    localparam int SPEED_BITS  = 16;
    localparam int GAIN_BITS   = 16;
    localparam int DRIVE_BITS  = 32;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic signed [SLOPE_BITS-1:0] RIGHT_SLOPE_LIMIT = SLOPE_BITS'(20);
    localparam logic signed [SLOPE_BITS-1:0] LEFT_SLOPE_LIMIT  = SLOPE_BITS'(20);
    localparam logic [SAMPLE_BITS-1:0]       RIGHT_ALT_REF     = SAMPLE_BITS'(0);
    localparam logic [SAMPLE_BITS-1:0]       LEFT_ALT_REF      = SAMPLE_BITS'(0);
    localparam logic [SAMPLE_BITS:0]         NEAR_WALL_OFFSET  = (SAMPLE_BITS + 1)'(20);

    localparam logic [SAMPLE_BITS-1:0] FRONT_LIMIT_RESET = {SAMPLE_BITS{1'b1}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRONT_LIMIT     = 3'd0,
        REG_MIN_SPEED       = 3'd1,
        REG_RIGHT_REF       = 3'd2,
        REG_LEFT_REF        = 3'd3,
        REG_RIGHT_THRESHOLD = 3'd4,
        REG_LEFT_THRESHOLD  = 3'd5,
        REG_P_GAIN          = 3'd6,
        REG_D_GAIN          = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                       active;
        logic [1:0]                 walls;
        logic signed [ERR_BITS-1:0] p;
        logic signed [DIFF_BITS-1:0] d;
    } err_stage_t;

endpackage

`default_nettype wire

### design/side_wall_pd_steering.sv
// Side-wall PD steering: wall detection, position error and PD drive.
// Depends on swps_pkg for widths, tuning constants and register indexes.
//
//   channel | direction | handshake            | beat
//   in      | sink      | in_valid / in_stall  | samples, slopes, speed, suppress
//   out     | source    | out_valid / out_stall| drive, active, walls_seen, position_error
//   cfg     | sink      | cfg_we               | cfg_index, cfg_data
//
// Two register stages: input capture, then wall decode, error and PD multiply-add
// into the result register. One beat per cycle sustained while out_stall is low;
// out_valid is registered with the result. Each stage advances independently, so a
// stalled output blocks input only once both stages are full.
// Reset clears all valid bits and the stored error and returns the config
// registers to their defaults.
`default_nettype none

module side_wall_pd_steering
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cfg_we,
    input  wire logic [swps_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [swps_pkg::CFG_BITS-1:0]         cfg_data,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [swps_pkg::SAMPLE_BITS-1:0]      front_sample,
    input  wire logic [swps_pkg::SAMPLE_BITS-1:0]      right_sample,
    input  wire logic [swps_pkg::SAMPLE_BITS-1:0]      left_sample,
    input  wire logic signed [swps_pkg::SLOPE_BITS-1:0] right_slope,
    input  wire logic signed [swps_pkg::SLOPE_BITS-1:0] left_slope,
    input  wire logic [swps_pkg::SPEED_BITS-1:0]       speed,
    input  wire logic                                  suppress,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [swps_pkg::DRIVE_BITS-1:0]     drive,
    output logic                                       active,
    output logic [1:0]                                 walls_seen,
    output logic signed [swps_pkg::ERR_BITS-1:0]       position_error
);

    localparam int SB = swps_pkg::SAMPLE_BITS;
    localparam int EB = swps_pkg::ERR_BITS;
    localparam int DB = swps_pkg::DIFF_BITS;
    localparam int GB = swps_pkg::GAIN_BITS;
    localparam int PB = GB + 1 + EB;
    localparam int QB = GB + 1 + DB;

    logic [SB-1:0]                     front_limit_reg;
    logic [swps_pkg::SPEED_BITS-1:0]   min_speed_reg;
    logic [SB-1:0]                     right_ref_reg;
    logic [SB-1:0]                     left_ref_reg;
    logic [SB-1:0]                     right_threshold_reg;
    logic [SB-1:0]                     left_threshold_reg;
    logic [GB-1:0]                     p_gain_reg;
    logic [GB-1:0]                     d_gain_reg;

    logic                              s1_valid_reg;
    logic [SB-1:0]                     s1_front_reg;
    logic [SB-1:0]                     s1_right_reg;
    logic [SB-1:0]                     s1_left_reg;
    logic signed [SB:0]                s1_rslope_reg;
    logic signed [SB:0]                s1_lslope_reg;
    logic [swps_pkg::SPEED_BITS-1:0]   s1_speed_reg;
    logic                              s1_suppress_reg;

    swps_pkg::err_stage_t              err_next;

    logic signed [EB-1:0]              last_error_reg;

    logic                              out_valid_reg;
    logic signed [swps_pkg::DRIVE_BITS-1:0] drive_reg;
    logic signed [swps_pkg::DRIVE_BITS-1:0] drive_next;
    logic                              active_reg;
    logic [1:0]                        walls_reg;
    logic signed [EB-1:0]              perr_reg;

    logic out_move;
    logic s1_move;
    logic in_take;
    logic s1_load;

    logic                run;
    logic                rsteep;
    logic                lsteep;
    logic [SB:0]         rthr;
    logic [SB:0]         lthr;
    logic [SB-1:0]       rref;
    logic [SB-1:0]       lref;
    logic                rw;
    logic                lw;
    logic signed [SB:0]  rdev;
    logic signed [SB:0]  ldev;
    logic signed [EB-1:0] p_sel;

    logic signed [PB-1:0] prod_p;
    logic signed [QB-1:0] prod_d;

    // handshake and stage movement
    assign out_move = !out_valid_reg || !out_stall;
    assign s1_move  = !s1_valid_reg || out_move;
    assign in_stall = !s1_move;
    assign in_take  = in_valid && s1_move;
    assign s1_load  = s1_valid_reg && out_move;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_limit_reg     <= swps_pkg::FRONT_LIMIT_RESET;
            min_speed_reg       <= '0;
            right_ref_reg       <= '0;
            left_ref_reg        <= '0;
            right_threshold_reg <= '0;
            left_threshold_reg  <= '0;
            p_gain_reg          <= '0;
            d_gain_reg          <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swps_pkg::REG_FRONT_LIMIT:     front_limit_reg     <= cfg_data[SB-1:0];
                swps_pkg::REG_MIN_SPEED:       min_speed_reg       <= cfg_data;
                swps_pkg::REG_RIGHT_REF:       right_ref_reg       <= cfg_data[SB-1:0];
                swps_pkg::REG_LEFT_REF:        left_ref_reg        <= cfg_data[SB-1:0];
                swps_pkg::REG_RIGHT_THRESHOLD: right_threshold_reg <= cfg_data[SB-1:0];
                swps_pkg::REG_LEFT_THRESHOLD:  left_threshold_reg  <= cfg_data[SB-1:0];
                swps_pkg::REG_P_GAIN:          p_gain_reg          <= cfg_data[GB-1:0];
                swps_pkg::REG_D_GAIN:          d_gain_reg          <= cfg_data[GB-1:0];
                default:                       ;
            endcase
        end
    end

    // stage 1: capture input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_front_reg    <= front_sample;
            s1_right_reg    <= right_sample;
            s1_left_reg     <= left_sample;
            s1_rslope_reg   <= right_slope;
            s1_lslope_reg   <= left_slope;
            s1_speed_reg    <= speed;
            s1_suppress_reg <= suppress;
        end
    end

    // wall decode and position error
    always_comb
    begin
        run    = !s1_suppress_reg && (s1_front_reg < front_limit_reg)
                 && (s1_speed_reg >= min_speed_reg);
        lsteep = s1_lslope_reg > swps_pkg::LEFT_SLOPE_LIMIT;
        rsteep = s1_rslope_reg > swps_pkg::RIGHT_SLOPE_LIMIT;

        lthr = lsteep ? ({1'b0, left_ref_reg} + swps_pkg::NEAR_WALL_OFFSET)
                      : {1'b0, left_threshold_reg};
        rref = lsteep ? swps_pkg::RIGHT_ALT_REF : right_ref_reg;
        rthr = rsteep ? ({1'b0, right_ref_reg} + swps_pkg::NEAR_WALL_OFFSET)
                      : {1'b0, right_threshold_reg};
        lref = rsteep ? swps_pkg::LEFT_ALT_REF : left_ref_reg;

        rw = {1'b0, s1_right_reg} >= rthr;
        lw = {1'b0, s1_left_reg} >= lthr;

        rdev = $signed({1'b0, s1_right_reg}) - $signed({1'b0, rref});
        ldev = $signed({1'b0, s1_left_reg}) - $signed({1'b0, lref});

        if (rw && lw)
        begin
            p_sel = $signed({rdev[SB], rdev}) - $signed({ldev[SB], ldev});
        end
        else if (rw)
        begin
            p_sel = $signed({rdev, 1'b0});
        end
        else if (lw)
        begin
            p_sel = $signed(EB'(0)) - $signed({ldev, 1'b0});
        end
        else
        begin
            p_sel = '0;
        end

        err_next.active = run;
        if (run)
        begin
            err_next.walls = {lw, rw};
            err_next.p     = p_sel;
            err_next.d     = $signed({p_sel[EB-1], p_sel})
                             - $signed({last_error_reg[EB-1], last_error_reg});
        end
        else
        begin
            err_next.walls = '0;
            err_next.p     = '0;
            err_next.d     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
        end
        else if (s1_load && err_next.active)
        begin
            last_error_reg <= err_next.p;
        end
    end

    // PD multiply-add into the result register
    assign prod_p = PB'($signed({1'b0, p_gain_reg}) * err_next.p);
    assign prod_d = QB'($signed({1'b0, d_gain_reg}) * err_next.d);
    assign drive_next = swps_pkg::DRIVE_BITS'($signed({prod_p[PB-1], prod_p}) + prod_d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            drive_reg  <= drive_next;
            active_reg <= err_next.active;
            walls_reg  <= err_next.walls;
            perr_reg   <= err_next.p;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive          = drive_reg;
    assign active         = active_reg;
    assign walls_seen     = walls_reg;
    assign position_error = perr_reg;

`ifndef SYNTHESIS
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |-> drive == 0 && walls_seen == 2'd0 && position_error == 0)
        else $error("inactive beat carries nonzero result");

    a_no_wall_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && walls_seen == 2'd0 |-> position_error == 0)
        else $error("position error without a wall");

    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_load && err_next.active) |=> $stable(last_error_reg))
        else $error("stored error changed without an active beat");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with an empty stage");
`endif

endmodule

`default_nettype wire
